>>> design/thrt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register codes for the raw-to-temperature pipeline.
// No dependencies; all design files but thrt_if and thrt_checker refer to it by scoped names.
package thrt_pkg;

   localparam int RAW_BITS = 16;
   localparam logic [15:0] RAW_MASK = 16'((32'd1 << RAW_BITS) - 32'd1);

   localparam logic [47:0] QCAP       = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] LN2_Q32    = 32'd2977044472;
   localparam logic [48:0] LOG_ONE    = 49'd65536;
   localparam logic [19:0] KELVIN_OFS = 20'd27315;
   localparam logic [18:0] K_MAX      = 19'd327315;
   localparam logic [19:0] TEMP_MAX   = 20'd300000;
   localparam logic [19:0] TEMP_MIN   = 20'hF954D;

   localparam int QDIV_STEPS = 48;
   localparam int SQ_STEPS   = 30;
   localparam int KDIV_STEPS = 19;

   typedef enum logic [3:0] {
      CSR_SWAP_BYTES    = 4'd0,
      CSR_PLANCK_R1     = 4'd1,
      CSR_PLANCK_R2     = 4'd2,
      CSR_PLANCK_B      = 4'd3,
      CSR_PLANCK_F      = 4'd4,
      CSR_PLANCK_O      = 4'd5,
      CSR_OBJECT_GAIN   = 4'd6,
      CSR_OBJECT_OFFSET = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic        swap_bytes;
      logic [31:0] planck_r1;
      logic [31:0] planck_r2;
      logic [23:0] planck_b;
      logic [23:0] planck_f;
      logic [23:0] planck_o;
      logic [31:0] object_gain;
      logic [31:0] object_offset;
   } cfg_type;

   // front end -> quotient divider
   typedef struct packed {
      logic        nonpos;
      logic [64:0] den;
   } den_type;

   typedef struct packed {
      logic        nonpos;
      logic        cap;
      logic [64:0] den;
      logic [64:0] rem;
      logic [47:0] q;
   } qdiv_type;

   // quotient divider -> log unit
   typedef struct packed {
      logic        nonpos;
      logic        cap;
      logic [47:0] q;
   } quo_type;

   typedef struct packed {
      logic        nonpos;
      logic        cap;
      logic        gt;
      logic [5:0]  ip;
      logic [29:0] frac;
      logic [30:0] m;
   } sq_type;

   // log unit -> temperature divider
   typedef struct packed {
      logic        nonpos;
      logic        cap;
      logic [35:0] lval;
   } ln_type;

   typedef struct packed {
      logic        nonpos;
      logic        cap;
      logic        zero;
      logic        big;
      logic [35:0] lval;
      logic [35:0] rem;
      logic [18:0] nlo;
      logic [18:0] k;
   } kdiv_type;

endpackage

>>> design/thrt_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing.
interface thrt_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_sample;
   modport source (output valid, output raw_sample, input ready);
   modport sink (input valid, input raw_sample, output ready);
endinterface

interface thrt_rsp_if;
   logic        valid;
   logic        ready;
   logic [19:0] temp_centi_c;
   logic        out_of_range;
   modport source (output valid, output temp_centi_c, output out_of_range, input ready);
   modport sink (input valid, input temp_centi_c, input out_of_range, output ready);
endinterface

>>> design/thermal_raw_to_temperature.sv
`timescale 1ns / 1ps
// Top level of the raw thermal pixel to temperature converter.
// Uses thrt_pkg, thrt_if, thrt_front, thrt_qdiv, thrt_log and thrt_kdiv.
//
// Usage:
//  - req carries one raw sensor pixel per item (raw_sample, 16 bits).
//  - rsp carries one result per item: temp_centi_c (signed, 0.01 degC) and
//    out_of_range, in the order the items were taken.
//  - csr_we/csr_index/csr_wdata write the eight settings registers; write them
//    only while no item is in flight. Indexes above seven are dropped.
//  - Latency is 110 register stages: 4 front-end, 49 in the quotient divider (a load
//    stage, then one bit a stage), 35 in the log unit (30 of them squaring), 22 in
//    the temperature divider and output register.
//  - Throughput is one item per cycle while rsp is not stalled; the bit-per-stage
//    dividers and the squaring chain are fully pipelined, so the depth sets latency only.
//  - A stalled rsp freezes the whole pipeline in place; req.ready drops only
//    while a result waits on rsp, so nothing is lost or repeated.
//  - Reset (synchronous) empties the pipeline and loads the settings defaults.
module thermal_raw_to_temperature (
   input  logic        clock,
   input  logic        reset,
   thrt_req_if.sink    req,
   thrt_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   thrt_pkg::cfg_type cfg_ff;
   logic              adv;
   logic              fe_valid, qd_valid, lg_valid;
   thrt_pkg::den_type fe_data;
   thrt_pkg::quo_type qd_data;
   thrt_pkg::ln_type  lg_data;

   // Settings registers; masked to their widths, unknown indexes dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swap_bytes    <= 1'b1;
         cfg_ff.planck_r1     <= 32'd86453330;
         cfg_ff.planck_r2     <= 32'd53881473;
         cfg_ff.planck_b      <= 24'd384256;
         cfg_ff.planck_f      <= 24'd65536;
         cfg_ff.planck_o      <= 24'hE35400;
         cfg_ff.object_gain   <= 32'd16777216;
         cfg_ff.object_offset <= 32'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            thrt_pkg::CSR_SWAP_BYTES:    cfg_ff.swap_bytes    <= csr_wdata[0];
            thrt_pkg::CSR_PLANCK_R1:     cfg_ff.planck_r1     <= csr_wdata;
            thrt_pkg::CSR_PLANCK_R2:     cfg_ff.planck_r2     <= csr_wdata;
            thrt_pkg::CSR_PLANCK_B:      cfg_ff.planck_b      <= csr_wdata[23:0];
            thrt_pkg::CSR_PLANCK_F:      cfg_ff.planck_f      <= csr_wdata[23:0];
            thrt_pkg::CSR_PLANCK_O:      cfg_ff.planck_o      <= csr_wdata[23:0];
            thrt_pkg::CSR_OBJECT_GAIN:   cfg_ff.object_gain   <= csr_wdata;
            thrt_pkg::CSR_OBJECT_OFFSET: cfg_ff.object_offset <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance every stage unless a finished result is being held on rsp.
   assign adv       = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   thrt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .in_valid  (req.valid),
      .in_raw    (req.raw_sample),
      .out_valid (fe_valid),
      .out_data  (fe_data)
   );

   thrt_qdiv u_qdiv (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .in_valid  (fe_valid),
      .in_data   (fe_data),
      .out_valid (qd_valid),
      .out_data  (qd_data)
   );

   thrt_log u_log (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .in_valid  (qd_valid),
      .in_data   (qd_data),
      .out_valid (lg_valid),
      .out_data  (lg_data)
   );

   thrt_kdiv u_kdiv (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .in_valid  (lg_valid),
      .in_data   (lg_data),
      .out_valid (rsp.valid),
      .out_temp  (rsp.temp_centi_c),
      .out_flag  (rsp.out_of_range)
   );
endmodule

>>> design/thrt_front.sv
`timescale 1ns / 1ps
// Front end: byte swap, gain/offset correction and the Planck R2 product.
// Uses thrt_pkg.
module thrt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  thrt_pkg::cfg_type cfg,
   input  logic              in_valid,
   input  logic [15:0]       in_raw,
   output logic              out_valid,
   output thrt_pkg::den_type out_data
);
   logic [3:0]         valid_ff;
   logic [47:0]        prod_ff, prod_in;
   logic [32:0]        x_ff, x_in;
   logic               np1_ff, np1_in, np2_ff;
   logic [63:0]        plo_ff, plo_in;
   logic               xhi_ff;
   thrt_pkg::den_type  den_ff, den_in;
   logic [15:0]        s;
   logic signed [34:0] xs;

   always_comb begin
      s = cfg.swap_bytes ? {in_raw[7:0], in_raw[15:8]} : in_raw;
      s = s & thrt_pkg::RAW_MASK;
      prod_in = {32'd0, s} * {16'd0, cfg.object_gain};
      xs = $signed({3'b000, prod_ff[47:16]}) - 35'($signed(cfg.object_offset))
           + 35'($signed(cfg.planck_o));
      np1_in = xs[34] || (xs == 35'sd0);
      x_in = xs[32:0];
      plo_in = {32'd0, cfg.planck_r2} * {32'd0, x_ff[31:0]};
      den_in.nonpos = np2_ff;
      den_in.den = {1'b0, plo_ff} + (xhi_ff ? {1'b0, cfg.planck_r2, 32'd0} : 65'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         x_ff    <= x_in;
         np1_ff  <= np1_in;
         plo_ff  <= plo_in;
         xhi_ff  <= x_ff[32];
         np2_ff  <= np1_ff;
         den_ff  <= den_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_data  = den_ff;
endmodule

>>> design/thrt_qdiv.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage: q = floor(R1 * 2^44 / den), capped.
// Uses thrt_pkg.
module thrt_qdiv (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  thrt_pkg::cfg_type cfg,
   input  logic              in_valid,
   input  thrt_pkg::den_type in_data,
   output logic              out_valid,
   output thrt_pkg::quo_type out_data
);
   localparam int N = thrt_pkg::QDIV_STEPS;

   logic [N:0]         valid_ff;
   thrt_pkg::qdiv_type stage_ff [N+1];
   thrt_pkg::qdiv_type stage_in [N+1];
   logic [47:0]        numlo;
   logic [65:0]        t    [N];
   logic [65:0]        diff [N];
   logic               ge   [N];

   always_comb begin
      numlo = {cfg.planck_r1[3:0], 44'd0};
      // quotient overflows 48 bits exactly when R1 >= 16 * den
      stage_in[0].nonpos = in_data.nonpos;
      stage_in[0].den    = in_data.den;
      stage_in[0].cap    = (in_data.den == 65'd0)
                           || ({37'd0, cfg.planck_r1} >= {in_data.den, 4'd0});
      stage_in[0].rem    = {37'd0, cfg.planck_r1[31:4]};
      stage_in[0].q      = '0;
      for (int j = 0; j < N; j++) begin
         t[j]    = {stage_ff[j].rem, numlo[N-1-j]};
         diff[j] = t[j] - {1'b0, stage_ff[j].den};
         ge[j]   = t[j] >= {1'b0, stage_ff[j].den};
         stage_in[j+1]     = stage_ff[j];
         stage_in[j+1].rem = ge[j] ? diff[j][64:0] : t[j][64:0];
         stage_in[j+1].q   = {stage_ff[j].q[46:0], ge[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[N-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j <= N; j++) begin
            stage_ff[j] <= stage_in[j];
         end
      end
   end

   assign out_valid       = valid_ff[N];
   assign out_data.nonpos = stage_ff[N].nonpos;
   assign out_data.cap    = stage_ff[N].cap;
   assign out_data.q      = stage_ff[N].cap ? thrt_pkg::QCAP : stage_ff[N].q;
endmodule

>>> design/thrt_log.sv
`timescale 1ns / 1ps
// Natural log of (q + F) / 2^16: leading-one search, normalize, squaring stages, ln 2 scale.
// Uses thrt_pkg.
module thrt_log (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  thrt_pkg::cfg_type cfg,
   input  logic              in_valid,
   input  thrt_pkg::quo_type in_data,
   output logic              out_valid,
   output thrt_pkg::ln_type  out_data
);
   localparam int S     = thrt_pkg::SQ_STEPS;
   localparam int DEPTH = S + 5;

   logic [DEPTH-1:0]   valid_ff;
   // add stage
   logic [48:0]        a0_ff, a0_in;
   logic               np0_ff, cap0_ff;
   // leading-one stage
   logic [48:0]        a1_ff;
   logic [5:0]         k1_ff, k1_in;
   logic               gt1_ff, gt1_in, np1_ff, cap1_ff;
   // squaring stages
   thrt_pkg::sq_type   sq_ff [S+1];
   thrt_pkg::sq_type   sq_in [S+1];
   logic [61:0]        sq    [S];
   logic [31:0]        m2    [S];
   logic [48:0]        shl, shr;
   // ln 2 scaling
   logic [35:0]        lg;
   logic [63:0]        plo_ff, plo_in;
   logic [35:0]        phi_ff, phi_in;
   logic               gtm_ff, npm_ff, capm_ff;
   logic [36:0]        lsum;
   thrt_pkg::ln_type   ln_ff, ln_in;

   always_comb begin
      a0_in = {1'b0, in_data.q} + {25'd0, cfg.planck_f};

      gt1_in = a0_ff > thrt_pkg::LOG_ONE;
      k1_in  = '0;
      for (int i = 0; i < 49; i++) begin
         if (a0_ff[i]) k1_in = 6'(i);
      end

      // normalize to Q1.30
      shr = a1_ff >> (k1_ff - 6'd30);
      shl = a1_ff << (6'd30 - k1_ff);
      sq_in[0].nonpos = np1_ff;
      sq_in[0].cap    = cap1_ff;
      sq_in[0].gt     = gt1_ff;
      sq_in[0].ip     = k1_ff - 6'd16;
      sq_in[0].frac   = '0;
      sq_in[0].m      = (k1_ff > 6'd30) ? shr[30:0] : shl[30:0];

      for (int j = 0; j < S; j++) begin
         sq[j] = {31'd0, sq_ff[j].m} * {31'd0, sq_ff[j].m};
         m2[j] = sq[j][61:30];
         sq_in[j+1]      = sq_ff[j];
         sq_in[j+1].frac = {sq_ff[j].frac[28:0], m2[j][31]};
         sq_in[j+1].m    = m2[j][31] ? m2[j][31:1] : m2[j][30:0];
      end

      lg     = {sq_ff[S].ip, sq_ff[S].frac};
      plo_in = {32'd0, lg[31:0]} * {32'd0, thrt_pkg::LN2_Q32};
      phi_in = {32'd0, lg[35:32]} * {4'd0, thrt_pkg::LN2_Q32};

      lsum         = {5'd0, plo_ff[63:32]} + {1'b0, phi_ff};
      ln_in.nonpos = npm_ff;
      ln_in.cap    = capm_ff;
      ln_in.lval   = gtm_ff ? lsum[35:0] : 36'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a0_ff   <= a0_in;
         np0_ff  <= in_data.nonpos;
         cap0_ff <= in_data.cap;
         a1_ff   <= a0_ff;
         k1_ff   <= k1_in;
         gt1_ff  <= gt1_in;
         np1_ff  <= np0_ff;
         cap1_ff <= cap0_ff;
         for (int j = 0; j <= S; j++) begin
            sq_ff[j] <= sq_in[j];
         end
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         gtm_ff  <= sq_ff[S].gt;
         npm_ff  <= sq_ff[S].nonpos;
         capm_ff <= sq_ff[S].cap;
         ln_ff   <= ln_in;
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = ln_ff;
endmodule

>>> design/thrt_kdiv.sv
`timescale 1ns / 1ps
// Temperature divider K = round(B * 100 * 2^22 / L), saturation and response register.
// Uses thrt_pkg.
module thrt_kdiv (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  thrt_pkg::cfg_type cfg,
   input  logic              in_valid,
   input  thrt_pkg::ln_type  in_data,
   output logic              out_valid,
   output logic [19:0]       out_temp,
   output logic              out_flag
);
   localparam int N     = thrt_pkg::KDIV_STEPS;
   localparam int DEPTH = N + 3;

   logic [DEPTH-1:0]   valid_ff;
   logic [53:0]        n_ff, n_in;
   logic [35:0]        l0_ff;
   logic               np0_ff, cap0_ff;
   logic [30:0]        b100;
   thrt_pkg::kdiv_type st_ff [N+1];
   thrt_pkg::kdiv_type st_in [N+1];
   logic [36:0]        t    [N];
   logic [36:0]        diff [N];
   logic               ge   [N];
   logic [19:0]        temp_ff, temp_in;
   logic               flag_ff, flag_in;

   always_comb begin
      b100 = {7'd0, cfg.planck_b} * 31'd100;
      n_in = {1'b0, b100, 22'd0} + {19'd0, in_data.lval[35:1]};

      st_in[0].nonpos = np0_ff;
      st_in[0].cap    = cap0_ff;
      st_in[0].zero   = (l0_ff == 36'd0);
      st_in[0].big    = {1'b0, n_ff} >= {l0_ff, 19'd0};
      st_in[0].lval   = l0_ff;
      st_in[0].rem    = {1'b0, n_ff[53:19]};
      st_in[0].nlo    = n_ff[18:0];
      st_in[0].k      = '0;
      for (int j = 0; j < N; j++) begin
         t[j]    = {st_ff[j].rem, st_ff[j].nlo[N-1-j]};
         diff[j] = t[j] - {1'b0, st_ff[j].lval};
         ge[j]   = t[j] >= {1'b0, st_ff[j].lval};
         st_in[j+1]     = st_ff[j];
         st_in[j+1].rem = ge[j] ? diff[j][35:0] : t[j][35:0];
         st_in[j+1].k   = {st_ff[j].k[17:0], ge[j]};
      end

      // below absolute zero wins, then log failure, then over-range
      if (st_ff[N].nonpos) begin
         temp_in = thrt_pkg::TEMP_MIN;
         flag_in = 1'b1;
      end else if (st_ff[N].zero || st_ff[N].big || (st_ff[N].k > thrt_pkg::K_MAX)) begin
         temp_in = thrt_pkg::TEMP_MAX;
         flag_in = 1'b1;
      end else begin
         temp_in = {1'b0, st_ff[N].k} - thrt_pkg::KELVIN_OFS;
         flag_in = st_ff[N].cap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff    <= n_in;
         l0_ff   <= in_data.lval;
         np0_ff  <= in_data.nonpos;
         cap0_ff <= in_data.cap;
         for (int j = 0; j <= N; j++) begin
            st_ff[j] <= st_in[j];
         end
         temp_ff <= temp_in;
         flag_ff <= flag_in;
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_temp  = temp_ff;
   assign out_flag  = flag_ff;
endmodule

>>> design/thrt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the converter, bound to the top level.
// Depends on thermal_raw_to_temperature.
module thrt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [19:0] rsp_temp,
   input logic        rsp_flag
);
   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temp) && $stable(rsp_flag))
      else $error("stalled result changed");

   // never refuse an item while the output is free
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input refused with empty output");

   // temperature stays inside its saturated range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_temp) >= -20'sd27315) && ($signed(rsp_temp) <= 20'sd300000))
      else $error("temperature outside range");

   // reset empties the pipeline
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result after reset");
endmodule

bind thermal_raw_to_temperature thrt_checker u_thrt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_temp  (rsp.temp_centi_c),
   .rsp_flag  (rsp.out_of_range)
);
